FILE: rtl/dar_pkg.sv
// shared types, constants and byte functions of the dns a-record responder
// no dependencies
`default_nettype none

package dar_pkg;

    localparam int unsigned MAX_LEN_DEFAULT   = 512;
    localparam int unsigned QUEUE_DEPTH       = 4;
    localparam int unsigned ANSWER_LEN        = 16;

    localparam logic [7:0]  FLAGS_QR_AA       = 8'h84;
    localparam logic [7:0]  PTR_MASK          = 8'hC0;
    localparam logic [7:0]  ANS_PTR_HI        = 8'hC0;
    localparam logic [7:0]  ANS_PTR_LO        = 8'h0C;
    localparam logic [7:0]  ANS_TTL_LO        = 8'd60;
    localparam logic [7:0]  ANS_RDLEN_LO      = 8'h04;
    localparam logic [7:0]  TYPE_A_LO         = 8'h01;
    localparam int unsigned HEADER_LAST_POS   = 11;
    localparam int unsigned MIN_FRAME_LEN     = 13;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN,
        PH_LABEL,
        PH_PTR,
        PH_TAIL,
        PH_DONE
    } name_phase_t;

    typedef enum logic {
        BK_HEAD,
        BK_TAIL
    } bk_state_t;

    // one queue word from the parser to the emitter
    typedef struct packed {
        logic       echo;
        logic [7:0] data;
        logic       last;
        logic       keep;
    } dar_entry_t;

    function automatic logic [7:0] header_byte(input logic [3:0] p, input logic [7:0] b);
        logic [7:0] r;
        unique case (p) inside
            4'd2:                      r = b | FLAGS_QR_AA;
            4'd7:                      r = 8'h01;
            4'd6, 4'd8, 4'd9, 4'd10,
            4'd11:                     r = 8'h00;
            default:                   r = b;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] answer_byte(input logic [3:0] idx, input logic [31:0] ip);
        logic [7:0] r;
        unique case (idx) inside
            4'd0:                             r = ANS_PTR_HI;
            4'd1:                             r = ANS_PTR_LO;
            4'd3, 4'd5:                       r = TYPE_A_LO;
            4'd9:                             r = ANS_TTL_LO;
            4'd11:                            r = ANS_RDLEN_LO;
            4'd12:                            r = ip[31:24];
            4'd13:                            r = ip[23:16];
            4'd14:                            r = ip[15:8];
            4'd15:                            r = ip[7:0];
            default:                          r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dns_a_record_responder.sv
// top level of the dns a-record responder
// depends on dar_pkg, dar_front, dar_queue, dar_back
//
// usage
//   query words enter on in_valid/in_ready with in_byte and in_last; one word
//   per cycle is taken while the four-entry queue has room
//   response words leave on out_valid/out_ready with out_byte, out_last, keep
//   answer_ip is written on cfg_valid (cfg_ready is always high); write it
//   only while no frame is in flight, which the block does not enforce
// path
//   an echoed byte passes through the queue and then the output register
// throughput
//   one word per cycle in and out while the queue has room and out_ready is
//   high; a kept frame's final word adds 16 answer words, a discarded frame
//   ends with one marker word (byte 0, keep 0), which can fill the queue
// reset
//   rst_n clears the parser, the queue, out_valid and the stored answer_ip
// stall
//   a held out_ready freezes the output word; the queue fills and in_ready
//   drops, nothing is lost
`default_nettype none

module dns_a_record_responder
    import dar_pkg::*;
#(
    parameter int unsigned MaxLen     = MAX_LEN_DEFAULT,
    parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             keep,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] answer_ip
);

    logic        ip_valid_unused;
    logic [31:0] ip_reg;
    logic        push, pop, empty, full, acc;
    dar_entry_t  push_entry, head;

    assign cfg_ready       = 1'b1;
    assign ip_valid_unused = 1'b0;
    assign in_ready        = !full;
    assign acc             = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ip_reg <= 32'd0;
        else if (cfg_valid && cfg_ready && !ip_valid_unused)
            ip_reg <= answer_ip;
    end

    dar_front #(.MaxLen(MaxLen)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc        (acc),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .push       (push),
        .push_entry (push_entry)
    );

    dar_queue #(.Depth(QueueDepth)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    dar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .ip        (ip_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .keep      (keep)
    );

endmodule

`default_nettype wire

FILE: rtl/dar_front.sv
// query parser: walks header and first question one byte per cycle
// while acc is high; depends on dar_pkg
`default_nettype none

module dar_front
    import dar_pkg::*;
#(
    parameter int unsigned MaxLen = MAX_LEN_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       acc,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            push,
    output dar_entry_t      push_entry
);

    localparam int unsigned PosW = $clog2(MaxLen + 1);

    logic [PosW-1:0] pos_reg, pos_next, pos_adv;
    name_phase_t     phase_reg, phase_next, phase_adv;
    logic [7:0]      left_reg, left_next, left_dec;
    logic [2:0]      tcnt_reg, tcnt_next;
    logic            qcn_reg, qcn_next;
    logic [7:0]      thigh_reg, thigh_next;
    logic            isa_reg, isa_next;
    logic            in_range, step, keep_calc;

    assign in_range = pos_reg < PosW'(MaxLen);
    assign step     = acc && in_range;
    assign left_dec = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;
    assign pos_adv  = step ? pos_reg + PosW'(1) : pos_reg;

    // next phase
    always_comb
    begin
        phase_adv = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_HEADER: if (pos_reg == PosW'(HEADER_LAST_POS)) phase_adv = PH_LEN;
                PH_LEN:
                begin
                    if (in_byte == 8'd0)
                        phase_adv = PH_TAIL;
                    else if ((in_byte & PTR_MASK) == PTR_MASK)
                        phase_adv = PH_PTR;
                    else
                        phase_adv = PH_LABEL;
                end
                PH_LABEL:  if (left_dec == 8'd0) phase_adv = PH_LEN;
                PH_PTR:    phase_adv = PH_TAIL;
                PH_TAIL:   if (tcnt_reg == 3'd3) phase_adv = PH_DONE;
                PH_DONE:   phase_adv = PH_DONE;
                default:   phase_adv = PH_HEADER;
            endcase
        end
        phase_next = (acc && in_last) ? PH_HEADER : phase_adv;
    end

    // parse fields and queue word
    always_comb
    begin
        left_next  = left_reg;
        tcnt_next  = tcnt_reg;
        qcn_next   = qcn_reg;
        thigh_next = thigh_reg;
        isa_next   = isa_reg;
        if (step)
        begin
            case (phase_reg)
                PH_HEADER:
                    if ((pos_reg == PosW'(4) || pos_reg == PosW'(5)) && in_byte != 8'd0)
                        qcn_next = 1'b1;
                PH_LEN:
                begin
                    if (in_byte == 8'd0)
                        tcnt_next = 3'd0;
                    else if ((in_byte & PTR_MASK) != PTR_MASK)
                        left_next = in_byte;
                end
                PH_LABEL: left_next = left_dec;
                PH_PTR:   tcnt_next = 3'd0;
                PH_TAIL:
                begin
                    if (tcnt_reg == 3'd0)
                        thigh_next = in_byte;
                    else if (tcnt_reg == 3'd1)
                        isa_next = (thigh_reg == 8'd0) && (in_byte == TYPE_A_LO);
                    tcnt_next = tcnt_reg + 3'd1;
                end
                default: ;
            endcase
        end

        keep_calc = (phase_adv == PH_DONE) && qcn_next && isa_next &&
                    (pos_adv >= PosW'(MIN_FRAME_LEN));

        push_entry.echo = in_range && (phase_reg != PH_DONE);
        push_entry.data = (phase_reg == PH_HEADER) ? header_byte(pos_reg[3:0], in_byte)
                                                   : in_byte;
        push_entry.last = in_last;
        push_entry.keep = keep_calc;
        push            = acc && (push_entry.echo || in_last);

        pos_next = pos_adv;
        if (acc && in_last)
        begin
            pos_next   = '0;
            left_next  = 8'd0;
            tcnt_next  = 3'd0;
            qcn_next   = 1'b0;
            thigh_next = 8'd0;
            isa_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_HEADER;
            left_reg  <= 8'd0;
            tcnt_reg  <= 3'd0;
            qcn_reg   <= 1'b0;
            thigh_reg <= 8'd0;
            isa_reg   <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            left_reg  <= left_next;
            tcnt_reg  <= tcnt_next;
            qcn_reg   <= qcn_next;
            thigh_reg <= thigh_next;
            isa_reg   <= isa_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dar_queue.sv
// short flop queue between parser and emitter
// depends on dar_pkg
`default_nettype none

module dar_queue
    import dar_pkg::*;
#(
    parameter int unsigned Depth = QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire dar_entry_t push_entry,
    input  wire logic       pop,
    output dar_entry_t      head,
    output logic            empty,
    output logic            full
);

    localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    dar_entry_t      mem_reg [Depth];
    logic [IdxW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign empty   = cnt_reg == '0;
    assign full    = cnt_reg == CntW'(Depth);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == IdxW'(Depth - 1)) ? '0 : wr_reg + IdxW'(1);
        if (do_pop)
            rd_next = (rd_reg == IdxW'(Depth - 1)) ? '0 : rd_reg + IdxW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CntW'(1);
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dar_back.sv
// emitter: echoes queued bytes, appends the a answer or the discard word
// depends on dar_pkg
`default_nettype none

module dar_back
    import dar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dar_entry_t  head,
    input  wire logic        empty,
    output logic             pop,
    input  wire logic [31:0] ip,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             keep
);

    bk_state_t  state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic       ol_reg, ol_next;
    logic       ok_reg, ok_next;
    logic       slot_free, go, do_echo;

    assign slot_free = !ov_reg || out_ready;
    assign go        = slot_free && !empty;
    assign do_echo   = (state_reg == BK_HEAD) && head.echo;

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (go)
        begin
            unique case (state_reg)
                BK_HEAD:
                    if (head.echo)
                        state_next = head.last ? BK_TAIL : BK_HEAD;
                    else if (head.keep && idx_reg != 4'(ANSWER_LEN - 1))
                        state_next = BK_TAIL;
                BK_TAIL:
                    if (!head.keep || idx_reg == 4'(ANSWER_LEN - 1))
                        state_next = BK_HEAD;
                default: state_next = BK_HEAD;
            endcase
        end
    end

    // word selection
    always_comb
    begin
        pop      = 1'b0;
        idx_next = idx_reg;
        ov_next  = ov_reg && !out_ready;
        ob_next  = ob_reg;
        ol_next  = ol_reg;
        ok_next  = ok_reg;
        if (go)
        begin
            ov_next = 1'b1;
            if (do_echo)
            begin
                ob_next = head.data;
                ol_next = 1'b0;
                ok_next = 1'b0;
                pop     = !head.last;
            end
            else if (head.keep)
            begin
                ob_next = answer_byte(idx_reg, ip);
                ol_next = idx_reg == 4'(ANSWER_LEN - 1);
                ok_next = idx_reg == 4'(ANSWER_LEN - 1);
                pop     = idx_reg == 4'(ANSWER_LEN - 1);
                idx_next = idx_reg + 4'd1;
            end
            else
            begin
                ob_next = 8'h00;
                ol_next = 1'b1;
                ok_next = 1'b0;
                pop     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_HEAD;
            idx_reg   <= 4'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        ol_reg <= ol_next;
        ok_reg <= ok_next;
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;
    assign keep      = ok_reg;

endmodule

`default_nettype wire

FILE: rtl/dar_checker.sv
// port-level checks of the dns a-record responder, bound to the top level
// depends on dns_a_record_responder
`default_nettype none

module dar_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       out_last,
    input  wire logic       keep,
    input  wire logic       cfg_ready
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
        $stable(out_last) && $stable(keep))
        else $error("output word changed under stall");

    // keep only on the final word
    a_keep_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && keep |-> out_last)
        else $error("keep without out_last");

    // discard marker carries a zero byte
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last && !keep |-> out_byte == 8'h00)
        else $error("discard marker with nonzero byte");

    // config port always ready
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind dns_a_record_responder dar_checker u_dar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .keep      (keep),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
